>>> rtl/periodic_timer_bank_top_defines.svh
// Assertion macros shared by the periodic timer bank checkers.
`ifndef PERIODIC_TIMER_BANK_TOP_DEFINES_SVH
`define PERIODIC_TIMER_BANK_TOP_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define PTB_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) expr) else $error(msg);

// Clocked assertion that is also checked while reset is high.
`define PTB_ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) expr) else $error(msg);

`endif

>>> rtl/ptb_pkg.sv
// Shared codes and types for the periodic timer bank.
package ptb_pkg;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_FIRE = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  localparam int SLOT_ID_WIDTH = 4;
  localparam int PERIOD_WIDTH  = 16;

  // Per-cell command, already qualified by the slot select.
  typedef struct packed {
    logic start;
    logic stop;
  } cell_cmd_t;

endpackage

>>> rtl/ptb_cell.sv
// One timer slot: active flag, interval and elapsed count, with a scan token stage.
module ptb_cell #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ptb_pkg::cell_cmd_t     cmd,
  input  logic [COUNT_WIDTH-1:0] period,
  input  logic                   tok_in,
  output logic                   tok_out,
  output logic                   fire
);

  logic                   active;
  logic                   tok_q;
  logic [COUNT_WIDTH-1:0] period_q;
  logic [COUNT_WIDTH-1:0] elapsed;
  logic [COUNT_WIDTH:0]   elapsed_inc;
  logic                   hit;

  assign elapsed_inc = {1'b0, elapsed} + {{COUNT_WIDTH{1'b0}}, 1'b1};
  assign hit         = elapsed_inc >= {1'b0, period_q};
  assign fire        = tok_q & active & hit;
  assign tok_out     = tok_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      tok_q  <= 1'b0;
    end else begin
      tok_q <= tok_in;
      if (cmd.start) begin
        active <= 1'b1;
      end else if (cmd.stop) begin
        active <= 1'b0;
      end
    end
  end

  // The cell only advances while it holds the scan token.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      period_q <= period;
      elapsed  <= '0;
    end else if (tok_q && active) begin
      elapsed <= hit ? '0 : elapsed_inc[COUNT_WIDTH-1:0];
    end
  end

endmodule

>>> rtl/periodic_timer_bank_top.sv
// A start or stop is acknowledged in the cycle after acceptance; busy stays low.
// A tick passes a token down the cell row, one slot per cycle, then enters a flush state;
// busy holds through the scan and the flush, so a new tick is taken only once both are done.
// Fires leave in ascending slot order, each held back one fire so the final one carries last.
// Synchronous reset clears all active flags, the token row and the output strobe.
// Results are shown for one cycle under valid; the receiver cannot stall.
module periodic_timer_bank_top #(
  parameter int NUM_SLOTS   = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [3:0]  slot_id,
  input  logic [15:0] period_ticks,
  output logic        valid,
  output logic        result_kind,
  output logic [3:0]  fired_slot,
  output logic        status,
  output logic        last
);

  // Only slots that a 4-bit slot id can name get a cell.
  localparam int CELLS = (NUM_SLOTS < 16) ? NUM_SLOTS : 16;
  localparam int IW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]             state;
  logic [IW-1:0]          scan_idx;
  logic                   pend_valid;
  logic [IW-1:0]          pend_slot;
  logic                   accept;
  logic                   slot_ok;
  logic                   start_ok;
  logic [31:0]            period_wide;
  logic [COUNT_WIDTH-1:0] period_sat;
  logic [CELLS-1:0]       sel;
  logic [CELLS:0]         tok;
  logic [CELLS-1:0]       fire;
  logic                   any_fire;

  ptb_pkg::cell_cmd_t cmd [CELLS];

  assign busy        = state != S_IDLE;
  assign accept      = start && !busy;
  assign slot_ok     = 32'(slot_id) < 32'(CELLS);
  assign start_ok    = slot_ok && (period_ticks != 16'd0);
  assign period_wide = 32'(period_ticks);
  assign period_sat  = (period_wide > COUNT_MAX) ? COUNT_MAX[COUNT_WIDTH-1:0]
                                                 : period_wide[COUNT_WIDTH-1:0];
  assign any_fire    = |fire;

  assign tok[0] = accept && (operation == ptb_pkg::OP_TICK);

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    assign sel[i]       = slot_id == 4'(i);
    assign cmd[i].start = accept && (operation == ptb_pkg::OP_START) && start_ok && sel[i];
    assign cmd[i].stop  = accept && (operation == ptb_pkg::OP_STOP) && sel[i];

    ptb_cell #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .cmd    (cmd[i]),
      .period (period_sat),
      .tok_in (tok[i]),
      .tok_out(tok[i+1]),
      .fire   (fire[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      scan_idx   <= '0;
      pend_valid <= 1'b0;
      valid      <= 1'b0;
    end else begin
      valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          scan_idx   <= '0;
          pend_valid <= 1'b0;
          if (accept) begin
            if (operation == ptb_pkg::OP_TICK) begin
              state <= S_SCAN;
            end else if (operation == ptb_pkg::OP_START || operation == ptb_pkg::OP_STOP) begin
              valid <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          // A new fire releases the one held back, which therefore is not the last.
          if (any_fire) begin
            pend_valid <= 1'b1;
            valid      <= pend_valid;
          end
          if (scan_idx == IW'(CELLS - 1)) begin
            state <= S_FLUSH;
          end else begin
            scan_idx <= scan_idx + IW'(1);
          end
        end
        S_FLUSH: begin
          valid      <= pend_valid;
          pend_valid <= 1'b0;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      result_kind <= ptb_pkg::KIND_ACK;
      fired_slot  <= slot_id;
      status      <= (operation == ptb_pkg::OP_START && !start_ok) ?
                     ptb_pkg::STATUS_REJECTED : ptb_pkg::STATUS_OK;
      last        <= 1'b1;
    end else if (state == S_SCAN && any_fire) begin
      pend_slot   <= scan_idx;
      result_kind <= ptb_pkg::KIND_FIRE;
      fired_slot  <= 4'(pend_slot);
      status      <= ptb_pkg::STATUS_OK;
      last        <= 1'b0;
    end else if (state == S_FLUSH) begin
      result_kind <= ptb_pkg::KIND_FIRE;
      fired_slot  <= 4'(pend_slot);
      status      <= ptb_pkg::STATUS_OK;
      last        <= 1'b1;
    end
  end

endmodule

>>> rtl/ptb_checker.sv
// Port-level checks for the periodic timer bank, bound to the top level.
`include "periodic_timer_bank_top_defines.svh"

module ptb_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  operation,
  input logic [3:0]  slot_id,
  input logic [15:0] period_ticks,
  input logic        valid,
  input logic        result_kind,
  input logic [3:0]  fired_slot,
  input logic        status,
  input logic        last
);

  // A start or stop transaction is acknowledged in the next cycle as a single result.
  `PTB_ASSERT(a_ack_follows, (start && !busy && (operation == ptb_pkg::OP_START || operation == ptb_pkg::OP_STOP)) |=> (valid && result_kind == ptb_pkg::KIND_ACK && last), "start or stop not acknowledged")

  // An acknowledgement only ever follows an accepted transaction.
  `PTB_ASSERT(a_ack_cause, (valid && result_kind == ptb_pkg::KIND_ACK) |-> $past(start && !busy), "acknowledgement without a transaction")

  // Fires always report success.
  `PTB_ASSERT(a_fire_ok, (valid && result_kind == ptb_pkg::KIND_FIRE) |-> (status == ptb_pkg::STATUS_OK), "fire with error status")

  // A tick occupies the block for the scan.
  `PTB_ASSERT(a_tick_busy, (start && !busy && operation == ptb_pkg::OP_TICK) |=> busy, "tick did not start a scan")

  `PTB_ASSERT_ALWAYS(a_reset_quiet, rst |=> (!valid && !busy), "outputs active after reset")

endmodule

bind periodic_timer_bank_top ptb_checker u_ptb_checker (.*);

>>> dv/tb_top.sv
// Self-checking testbench for the periodic timer bank: drives commands and checks every result.
module tb_top;

  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam int TIMER_SLOTS = 16;
  localparam int RANDOM_COMMANDS = 330;
  localparam int QUIET_TAIL = 40;
  localparam int STALL_LIMIT = 500;

  typedef struct packed {
    logic       kind;
    logic [3:0] slot;
    logic       status;
    logic       last;
  } timer_event_t;

  // Tracks the timer slots and holds the acknowledgements and fires still owed by the block.
  class timer_event_board_t;
    logic                             active[TIMER_SLOTS];
    logic [ptb_pkg::PERIOD_WIDTH-1:0] interval[TIMER_SLOTS];
    logic [ptb_pkg::PERIOD_WIDTH-1:0] elapsed[TIMER_SLOTS];
    timer_event_t                     owed_events[$];
    int                               faults;

    function new();
      foreach (active[i]) active[i] = 1'b0;
      faults = 0;
    endfunction

    function void owe(logic kind, logic [3:0] slot, logic status, logic last);
      timer_event_t ev;
      ev.kind = kind;
      ev.slot = slot;
      ev.status = status;
      ev.last = last;
      owed_events.push_back(ev);
    endfunction

    function void accept_command(logic [1:0] op, logic [3:0] slot, logic [15:0] per);
      int top_fire;
      top_fire = -1;
      case (op)
        ptb_pkg::OP_START: begin
          if (per == '0) begin
            owe(ptb_pkg::KIND_ACK, slot, ptb_pkg::STATUS_REJECTED, 1'b1);
          end else begin
            active[slot] = 1'b1;
            interval[slot] = per;
            elapsed[slot] = '0;
            owe(ptb_pkg::KIND_ACK, slot, ptb_pkg::STATUS_OK, 1'b1);
          end
        end
        ptb_pkg::OP_STOP: begin
          active[slot] = 1'b0;
          owe(ptb_pkg::KIND_ACK, slot, ptb_pkg::STATUS_OK, 1'b1);
        end
        ptb_pkg::OP_TICK: begin
          // Find the highest slot that expires so its fire can carry the last flag.
          for (int i = 0; i < TIMER_SLOTS; i++) begin
            if (active[i] && elapsed[i] + 1 >= interval[i]) top_fire = i;
          end
          for (int i = 0; i < TIMER_SLOTS; i++) begin
            if (active[i]) begin
              elapsed[i] = elapsed[i] + 1'b1;
              if (elapsed[i] >= interval[i]) begin
                elapsed[i] = '0;
                owe(ptb_pkg::KIND_FIRE, i[3:0], ptb_pkg::STATUS_OK, i == top_fire);
              end
            end
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void report(string what);
      faults++;
      if (faults <= 10) $display("%0t: %s", $time, what);
    endfunction

    function void check_event(logic kind, logic [3:0] slot, logic status, logic last);
      timer_event_t ev;
      if (owed_events.size() == 0) begin
        report($sformatf("unexpected result kind=%0d slot=%0d status=%0d last=%0d",
                         kind, slot, status, last));
        return;
      end
      ev = owed_events.pop_front();
      if (ev.kind !== kind || ev.slot !== slot || ev.status !== status || ev.last !== last)
        report($sformatf({"mismatch: expected kind=%0d slot=%0d status=%0d last=%0d, ",
                          "got kind=%0d slot=%0d status=%0d last=%0d"},
                         ev.kind, ev.slot, ev.status, ev.last, kind, slot, status, last));
    endfunction

    function int owed_count();
      return owed_events.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  operation;
  logic [3:0]  slot_id;
  logic [15:0] period_ticks;
  logic        valid;
  logic        result_kind;
  logic [3:0]  fired_slot;
  logic        status;
  logic        last;

  timer_event_board_t board = new();
  int quiet_cycles = 0;

  periodic_timer_bank_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .slot_id     (slot_id),
    .period_ticks(period_ticks),
    .valid       (valid),
    .result_kind (result_kind),
    .fired_slot  (fired_slot),
    .status      (status),
    .last        (last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst && valid) board.check_event(result_kind, fired_slot, status, last);
  end

  // The run is stuck if neither a command nor a result moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("periodic_timer_bank_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_command(input logic [1:0] op, input logic [3:0] sid,
                              input logic [15:0] per);
    @(negedge clk);
    start <= 1'b1;
    operation <= op;
    slot_id <= sid;
    period_ticks <= per;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.accept_command(op, sid, per);
  endtask

  task automatic pause_sender(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_for_owed_results();
    while (board.owed_count() != 0) @(posedge clk);
  endtask

  initial begin
    int          cmd_count;
    int          pick;
    bit          drained;
    logic [1:0]  op;
    logic [3:0]  sid;
    logic [15:0] per;

    cmd_count = 0;
    drained = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    operation = ptb_pkg::OP_START;
    slot_id = '0;
    period_ticks = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: rejection, idle stop, empty tick, ignored code, extremes and reload.
    send_command(ptb_pkg::OP_START, 4'd0, 16'd0);
    send_command(ptb_pkg::OP_STOP, 4'd5, 16'd0);
    send_command(ptb_pkg::OP_TICK, 4'd9, 16'h1234);
    send_command(OP_IGNORED, 4'd15, 16'hFFFF);
    send_command(ptb_pkg::OP_START, 4'd15, 16'hFFFF);
    send_command(ptb_pkg::OP_START, 4'd0, 16'd1);
    send_command(ptb_pkg::OP_START, 4'd3, 16'd2);
    send_command(ptb_pkg::OP_TICK, 4'd0, 16'd0);
    send_command(ptb_pkg::OP_TICK, 4'd15, 16'hFFFF);
    send_command(ptb_pkg::OP_START, 4'd3, 16'd3);
    send_command(ptb_pkg::OP_TICK, 4'd0, 16'd0);
    send_command(ptb_pkg::OP_STOP, 4'd0, 16'hFFFF);
    send_command(ptb_pkg::OP_TICK, 4'd0, 16'd0);
    send_command(ptb_pkg::OP_TICK, 4'd0, 16'd0);
    send_command(ptb_pkg::OP_TICK, 4'd0, 16'd0);
    send_command(ptb_pkg::OP_STOP, 4'd15, 16'd0);
    send_command(ptb_pkg::OP_STOP, 4'd3, 16'd0);

    // Every slot fires on the same tick, the largest burst a single tick can cause.
    for (int i = 0; i < TIMER_SLOTS; i++) send_command(ptb_pkg::OP_START, i[3:0], 16'd1);
    send_command(ptb_pkg::OP_TICK, 4'd0, 16'd0);
    send_command(ptb_pkg::OP_TICK, 4'd7, 16'd0);
    for (int i = 0; i < TIMER_SLOTS; i++)
      send_command(ptb_pkg::OP_START, i[3:0], 16'($urandom_range(1, 6)));

    while (cmd_count < RANDOM_COMMANDS) begin
      if (cmd_count >= RANDOM_COMMANDS / 2 && !drained) begin
        pause_sender(1);
        wait_for_owed_results();
        drained = 1'b1;
      end
      if (cmd_count < RANDOM_COMMANDS - 60 && $urandom_range(0, 3) == 0)
        pause_sender($urandom_range(1, 13));
      pick = $urandom_range(0, 99);
      sid = 4'($urandom_range(0, 15));
      per = 16'($urandom);
      if (pick < 38) begin
        op = ptb_pkg::OP_TICK;
      end else if (pick < 70) begin
        op = ptb_pkg::OP_START;
        case ($urandom_range(0, 9))
          0: per = 16'($urandom);
          1: per = 16'hFFFF;
          default: per = 16'($urandom_range(1, 6));
        endcase
        if (per == '0) per = 16'd1;
      end else if (pick < 75) begin
        op = ptb_pkg::OP_START;
        per = '0;
      end else if (pick < 93) begin
        op = ptb_pkg::OP_STOP;
      end else begin
        op = OP_IGNORED;
      end
      send_command(op, sid, per);
      if (op != OP_IGNORED) cmd_count++;
    end

    pause_sender(1);
    wait_for_owed_results();
    repeat (QUIET_TAIL) @(posedge clk);
    if (board.faults == 0 && board.owed_count() == 0) begin
      $display("periodic_timer_bank_top regression: pass");
    end else begin
      $display("periodic_timer_bank_top regression: fail");
    end
    $finish;
  end

endmodule
